/* design/macs_pkg.sv */
// ============================================================================
// Moving average crossover package
// Beat layouts, register indexes and fixed widths shared by the crossover
// signal block and its response queue.
// ============================================================================
package macs_pkg;

   // Field widths fixed by the interface.
   localparam int SYM_W      = 4;
   localparam int PRICE_W    = 32;
   localparam int POS_W      = 32;
   localparam int QTY_W      = 31;
   localparam int FAST_W     = 6;
   localparam int SLOW_W     = 7;
   localparam int PERIOD_W   = SLOW_W;

   // Port widths.
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 1;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 31;

   // Period defaults and the largest values the period registers hold.
   localparam logic [PERIOD_W-1:0] DEFAULT_FAST = PERIOD_W'(10);
   localparam logic [PERIOD_W-1:0] DEFAULT_SLOW = PERIOD_W'(30);
   localparam int FAST_MAX = (1 << FAST_W) - 1;
   localparam int SLOW_MAX = (1 << SLOW_W) - 1;

   // Response queue sizing; the queue depth is also the limit on beats in flight or queued.
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

   // Register indexes on the configuration channel.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FAST_PERIOD  = 2'd0,
      CSR_SLOW_PERIOD  = 2'd1,
      CSR_BUY_QUANTITY = 2'd2
   } csr_index_type;

   // Order side codes.
   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   // Request beat, first field in the lowest bits.
   typedef struct packed {
      logic [3:0]              pad;
      logic signed [POS_W-1:0] current_position;
      logic [PRICE_W-1:0]      close_price;
      logic [SYM_W-1:0]        symbol;
   } req_beat_type;

   // One market order as it waits in the response queue.
   typedef struct packed {
      logic [QTY_W-1:0] order_quantity;
      logic             order_side;
      logic [SYM_W-1:0] order_symbol;
   } order_type;

endpackage

/* design/moving_average_crossover_signal.sv */
// ============================================================================
// Moving average crossover signal
// Per-symbol fast and slow simple moving averages over a ring of closing
// prices; emits a buy or sell order when the averages cross.
// ============================================================================
//
//   Channel  Direction  Handshake              Carries
//   req_     in         req_tvalid/req_tready  symbol, close_price, current_position
//   rsp_     out        rsp_tvalid/rsp_tready  order_symbol, order_quantity; side in tuser
//   csr_     in         csr_valid/csr_ready    register index and write data
//
// One beat is accepted per cycle while req_tready is high. A result passes the
// stage 1 to 4 registers and the response queue before it leaves; the per-symbol
// state memory read-modify-write forwards from the two most recent writes.
// req_tready drops while eight beats are in flight or queued for output.
// Reset clears per-symbol state at once through valid bits; there is no
// clearing pass. A period write clears the history the same way.
// csr_ready is always high.
//
module moving_average_crossover_signal #(
   parameter int NUM_SYMBOLS = 16,
   parameter int MAX_WINDOW  = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   // symbol [3:0], close_price [35:4], current_position [67:36], zero fill
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [macs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // order_symbol [3:0], order_quantity [34:4], zero fill
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [macs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // order_side [0]
   output logic [macs_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [macs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [macs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import macs_pkg::*;

   localparam int IDX_W    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
   localparam int SLOT_W   = $clog2(MAX_WINDOW);
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W    = PRICE_W + SLOT_W;
   localparam int RING_AW  = IDX_W + SLOT_W;
   localparam int RING_D   = NUM_SYMBOLS * (2 ** SLOT_W);
   localparam int WRAP_W   = SLOT_W + 2;
   localparam int CMP_W    = (CNT_W > PERIOD_W) ? CNT_W : PERIOD_W;
   localparam int PROD_W   = SUM_W + PERIOD_W;
   localparam int STATE_W  = CNT_W + SLOT_W + 2 * SUM_W;
   localparam int SYMC_W   = 9;
   localparam int FAST_CAP = (MAX_WINDOW - 1 < FAST_MAX) ? MAX_WINDOW - 1 : FAST_MAX;
   localparam int SLOW_CAP = (MAX_WINDOW < SLOW_MAX) ? MAX_WINDOW : SLOW_MAX;

   localparam logic [PERIOD_W-1:0] FAST_CAP_V = PERIOD_W'(FAST_CAP);
   localparam logic [PERIOD_W-1:0] SLOW_CAP_V = PERIOD_W'(SLOW_CAP);
   localparam logic [SLOT_W-1:0]   LAST_SLOT  = SLOT_W'(MAX_WINDOW - 1);
   localparam logic [CNT_W-1:0]    MW_CNT     = CNT_W'(MAX_WINDOW);
   localparam logic [WRAP_W-1:0]   MW_WRAP    = WRAP_W'(MAX_WINDOW);
   localparam logic [SYMC_W-1:0]   NSYM_V     = SYMC_W'(NUM_SYMBOLS);

   typedef struct packed {
      logic [CNT_W-1:0]  cnt;
      logic [SLOT_W-1:0] slot;
      logic [SUM_W-1:0]  fsum;
      logic [SUM_W-1:0]  ssum;
   } state_type;

   // Ring slot that lies p bars behind slot w.
   function automatic logic [SLOT_W-1:0] back_slot(input logic [SLOT_W-1:0]   w,
                                                   input logic [PERIOD_W-1:0] p);
      logic [WRAP_W-1:0] wx;
      logic [WRAP_W-1:0] px;
      logic [WRAP_W-1:0] r;
      wx = WRAP_W'(w);
      px = WRAP_W'(p);
      r  = (wx >= px) ? (wx - px) : (wx + MW_WRAP - px);
      return r[SLOT_W-1:0];
   endfunction

   // ---------------------------------------------------------------- config
   logic [FAST_W-1:0]   fast_period_ff;
   logic [SLOW_W-1:0]   slow_period_ff;
   logic [QTY_W-1:0]    buy_quantity_ff;
   logic                csr_write;
   logic                clear_hist;
   logic [PERIOD_W-1:0] fast_eff;
   logic [PERIOD_W-1:0] slow_eff;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign clear_hist = csr_write && ((csr_index == CSR_FAST_PERIOD) ||
                                     (csr_index == CSR_SLOW_PERIOD));

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff  <= FAST_W'(DEFAULT_FAST);
         slow_period_ff  <= SLOW_W'(DEFAULT_SLOW);
         buy_quantity_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAST_PERIOD:  fast_period_ff  <= csr_data[FAST_W-1:0];
            CSR_SLOW_PERIOD:  slow_period_ff  <= csr_data[SLOW_W-1:0];
            CSR_BUY_QUANTITY: buy_quantity_ff <= csr_data[QTY_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective windows: defaults, caps, then slow kept above fast.
   always_comb begin
      fast_eff = (fast_period_ff == '0) ? DEFAULT_FAST : PERIOD_W'(fast_period_ff);
      if (fast_eff > FAST_CAP_V) begin
         fast_eff = FAST_CAP_V;
      end
      slow_eff = (slow_period_ff == '0) ? DEFAULT_SLOW : slow_period_ff;
      if (slow_eff > SLOW_CAP_V) begin
         slow_eff = SLOW_CAP_V;
      end
      if (fast_eff >= slow_eff) begin
         slow_eff = fast_eff + PERIOD_W'(1);
      end
   end

   // ---------------------------------------------------------------- intake
   req_beat_type        req_beat;
   logic                req_acc;
   logic [IDX_W-1:0]    req_idx;
   logic [CREDIT_W-1:0] credit_ff;
   logic [CREDIT_W-1:0] credit_in;

   assign req_beat   = req_beat_type'(req_tdata);
   assign req_idx    = IDX_W'(req_beat.symbol);
   assign req_tready = (credit_ff < CREDIT_W'(FIFO_DEPTH));
   assign req_acc    = req_tvalid && req_tready;

   // ---------------------------------------------------------------- memories
   logic [STATE_W-1:0] st_rd_data;
   logic               st_wen;
   state_type          st_wr;
   logic               ring_wen;
   logic [RING_AW-1:0] ring_wr_addr;
   logic [RING_AW-1:0] ring_addr_f;
   logic [RING_AW-1:0] ring_addr_s;
   logic [PRICE_W-1:0] ring_q_f;
   logic [PRICE_W-1:0] ring_q_s;

   macs_state_ram #(
      .DEPTH  (NUM_SYMBOLS),
      .ADDR_W (IDX_W),
      .WIDTH  (STATE_W)
   ) u_state_ram (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear_hist),
      .wr_en   (st_wen),
      .wr_addr (s2_idx_ff),
      .wr_data (st_wr),
      .rd_addr (req_idx),
      .rd_data (st_rd_data)
   );

   macs_ring_ram #(
      .DEPTH  (RING_D),
      .ADDR_W (RING_AW),
      .WIDTH  (PRICE_W)
   ) u_ring_ram (
      .clock     (clock),
      .wr_en     (ring_wen),
      .wr_addr   (ring_wr_addr),
      .wr_data   (s2_price_ff),
      .rd_addr_a (ring_addr_f),
      .rd_data_a (ring_q_f),
      .rd_addr_b (ring_addr_s),
      .rd_data_b (ring_q_s)
   );

   // ---------------------------------------------------------------- stage 1
   logic                s1_valid_ff;
   logic                s1_act_ff;
   logic [IDX_W-1:0]    s1_idx_ff;
   logic [SYM_W-1:0]    s1_sym_ff;
   logic [PRICE_W-1:0]  s1_price_ff;
   logic [POS_W-1:0]    s1_pos_ff;

   // Stage 2 registers, declared here for the forwarding paths.
   logic                s2_valid_ff;
   logic                s2_act_ff;
   logic [IDX_W-1:0]    s2_idx_ff;
   logic [SYM_W-1:0]    s2_sym_ff;
   logic [PRICE_W-1:0]  s2_price_ff;
   logic [POS_W-1:0]    s2_pos_ff;
   logic [SLOT_W-1:0]   s2_slot_ff;
   logic [SLOT_W-1:0]   s2_new_slot_ff;
   logic [CNT_W-1:0]    s2_new_cnt_ff;
   logic                s2_sub_f_ff;
   logic                s2_sub_s_ff;
   logic [SUM_W-1:0]    s2_fsum_ff;
   logic [SUM_W-1:0]    s2_ssum_ff;
   logic                s2_emit_ff;
   logic                s2_byp_f_ff;
   logic                s2_byp_s_ff;
   logic [PRICE_W-1:0]  s2_byp_price_ff;

   // Last state written, for the read that overlapped that write.
   logic                lw_valid_ff;
   logic [IDX_W-1:0]    lw_idx_ff;
   state_type           lw_state_ff;

   state_type           st1;
   logic [SLOT_W-1:0]   s1_old_f;
   logic [SLOT_W-1:0]   s1_old_s;
   logic [SLOT_W-1:0]   s1_new_slot;
   logic [CNT_W-1:0]    s1_new_cnt;
   logic                s1_sub_f;
   logic                s1_sub_s;
   logic                s1_emit;

   // Intake registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_acc;
      end
      s1_act_ff   <= (SYMC_W'(req_beat.symbol) < NSYM_V);
      s1_idx_ff   <= req_idx;
      s1_sym_ff   <= req_beat.symbol;
      s1_price_ff <= req_beat.close_price;
      s1_pos_ff   <= req_beat.current_position;
   end

   // State forwarding: the beat in stage 2 first, then the last write.
   always_comb begin
      if (s2_valid_ff && s2_act_ff && (s2_idx_ff == s1_idx_ff)) begin
         st1 = st_wr;
      end else if (lw_valid_ff && (lw_idx_ff == s1_idx_ff)) begin
         st1 = lw_state_ff;
      end else begin
         st1 = state_type'(st_rd_data);
      end
   end

   // Window bookkeeping and ring read addresses.
   always_comb begin
      s1_sub_f    = (CMP_W'(st1.cnt) >= CMP_W'(fast_eff));
      s1_sub_s    = (CMP_W'(st1.cnt) >= CMP_W'(slow_eff));
      s1_old_f    = back_slot(st1.slot, fast_eff);
      s1_old_s    = back_slot(st1.slot, slow_eff);
      s1_new_slot = (st1.slot == LAST_SLOT) ? '0 : st1.slot + SLOT_W'(1);
      s1_new_cnt  = (st1.cnt < MW_CNT) ? st1.cnt + CNT_W'(1) : st1.cnt;
      s1_emit     = (CMP_W'(s1_new_cnt) >= CMP_W'(slow_eff));
   end

   assign ring_addr_f  = {s1_idx_ff, s1_old_f};
   assign ring_addr_s  = {s1_idx_ff, s1_old_s};
   assign ring_wen     = s2_valid_ff && s2_act_ff;
   assign ring_wr_addr = {s2_idx_ff, s2_slot_ff};

   // ---------------------------------------------------------------- stage 2
   logic [PRICE_W-1:0] s2_old_f;
   logic [PRICE_W-1:0] s2_old_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_act_ff       <= s1_act_ff;
      s2_idx_ff       <= s1_idx_ff;
      s2_sym_ff       <= s1_sym_ff;
      s2_price_ff     <= s1_price_ff;
      s2_pos_ff       <= s1_pos_ff;
      s2_slot_ff      <= st1.slot;
      s2_new_slot_ff  <= s1_new_slot;
      s2_new_cnt_ff   <= s1_new_cnt;
      s2_sub_f_ff     <= s1_sub_f;
      s2_sub_s_ff     <= s1_sub_s;
      s2_fsum_ff      <= st1.fsum;
      s2_ssum_ff      <= st1.ssum;
      s2_emit_ff      <= s1_emit;
      s2_byp_f_ff     <= ring_wen && (ring_wr_addr == ring_addr_f);
      s2_byp_s_ff     <= ring_wen && (ring_wr_addr == ring_addr_s);
      s2_byp_price_ff <= s2_price_ff;
   end

   // Slide both windows: drop the oldest price once the window is full.
   always_comb begin
      s2_old_f    = s2_byp_f_ff ? s2_byp_price_ff : ring_q_f;
      s2_old_s    = s2_byp_s_ff ? s2_byp_price_ff : ring_q_s;
      st_wr.cnt   = s2_new_cnt_ff;
      st_wr.slot  = s2_new_slot_ff;
      st_wr.fsum  = s2_fsum_ff - (s2_sub_f_ff ? SUM_W'(s2_old_f) : '0)
                    + SUM_W'(s2_price_ff);
      st_wr.ssum  = s2_ssum_ff - (s2_sub_s_ff ? SUM_W'(s2_old_s) : '0)
                    + SUM_W'(s2_price_ff);
   end

   assign st_wen = s2_valid_ff && s2_act_ff;

   // Copy of the state just written.
   always_ff @(posedge clock) begin
      if (reset || clear_hist) begin
         lw_valid_ff <= 1'b0;
      end else if (st_wen) begin
         lw_valid_ff <= 1'b1;
      end
      if (st_wen) begin
         lw_idx_ff   <= s2_idx_ff;
         lw_state_ff <= st_wr;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic               s3_valid_ff;
   logic               s3_emit_ff;
   logic [SYM_W-1:0]   s3_sym_ff;
   logic [POS_W-1:0]   s3_pos_ff;
   logic [SUM_W-1:0]   s3_fsum_ff;
   logic [SUM_W-1:0]   s3_ssum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_emit_ff <= s2_act_ff && s2_emit_ff;
      s3_sym_ff  <= s2_sym_ff;
      s3_pos_ff  <= s2_pos_ff;
      s3_fsum_ff <= st_wr.fsum;
      s3_ssum_ff <= st_wr.ssum;
   end

   // ---------------------------------------------------------------- stage 4
   // Cross-multiplied averages: fast_sum*S against slow_sum*F.
   logic               s4_valid_ff;
   logic               s4_emit_ff;
   logic [SYM_W-1:0]   s4_sym_ff;
   logic [POS_W-1:0]   s4_pos_ff;
   logic [PROD_W-1:0]  s4_lhs_ff;
   logic [PROD_W-1:0]  s4_rhs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_emit_ff <= s3_emit_ff;
      s4_sym_ff  <= s3_sym_ff;
      s4_pos_ff  <= s3_pos_ff;
      s4_lhs_ff  <= PROD_W'(s3_fsum_ff) * PROD_W'(slow_eff);
      s4_rhs_ff  <= PROD_W'(s3_ssum_ff) * PROD_W'(fast_eff);
   end

   // Order decision.
   logic       pos_gt0;
   logic       go_buy;
   logic       go_sell;
   logic       push;
   logic       pop;
   logic       drop;
   order_type  push_order;
   order_type  head_order;

   always_comb begin
      pos_gt0 = !s4_pos_ff[POS_W-1] && (s4_pos_ff != '0);
      go_buy  = s4_emit_ff && (s4_lhs_ff > s4_rhs_ff) && !pos_gt0;
      go_sell = s4_emit_ff && (s4_lhs_ff < s4_rhs_ff) && pos_gt0;
      push    = s4_valid_ff && (go_buy || go_sell);
      drop    = s4_valid_ff && !(go_buy || go_sell);
      push_order.order_symbol   = s4_sym_ff;
      push_order.order_side     = go_sell ? SIDE_SELL : SIDE_BUY;
      if (go_sell) begin
         push_order.order_quantity = s4_pos_ff[QTY_W-1:0];
      end else if (buy_quantity_ff != '0) begin
         push_order.order_quantity = buy_quantity_ff;
      end else begin
         push_order.order_quantity = QTY_W'(1);
      end
   end

   // ---------------------------------------------------------------- output
   macs_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push),
      .push_data  (push_order),
      .pop_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (head_order)
   );

   assign pop       = rsp_tvalid && rsp_tready;
   assign rsp_tdata = {(RSP_TDATA_W - QTY_W - SYM_W)'(0),
                       head_order.order_quantity, head_order.order_symbol};
   assign rsp_tuser = head_order.order_side;

   // Beats held in the pipeline or in the queue.
   assign credit_in = credit_ff + CREDIT_W'(req_acc) - CREDIT_W'(pop) - CREDIT_W'(drop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

endmodule

/* design/macs_ring_ram.sv */
// ============================================================================
// Price ring memory
// One write port and two read ports, read data registered, read-first when a
// read and a write hit the same entry in one cycle.
// ============================================================================
module macs_ring_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10,
   parameter int WIDTH  = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [WIDTH-1:0]  rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Both reads see the contents from before this cycle's write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* design/macs_state_ram.sv */
// ============================================================================
// Per-symbol state memory
// Holds bar count, write slot and both window sums for each symbol. A valid
// bit per entry makes an entry read as zero after reset or a history clear.
// ============================================================================
module macs_state_ram #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4,
   parameter int WIDTH  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_q_ff;
   logic [DEPTH-1:0] valid_ff;
   logic             rd_hit_ff;

   // Storage, read-first.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Valid bits are cleared all at once and set by each write.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         rd_hit_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_q_ff : '0;

endmodule

/* design/macs_rsp_fifo.sv */
// ============================================================================
// Response queue
// Small queue of market orders between the decision stage and the result
// channel. The producer never pushes into a full queue.
// ============================================================================
module macs_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  macs_pkg::order_type push_data,
   input  logic                pop_ready,
   output logic                out_valid,
   output macs_pkg::order_type out_data
);
   import macs_pkg::*;

   order_type           slots_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [CREDIT_W-1:0] count_ff;
   logic                pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = slots_ff[rd_ptr_ff];
   assign pop       = out_valid && pop_ready;

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CREDIT_W'(push_valid) - CREDIT_W'(pop);
      end
   end

endmodule

/* design/macs_port_checker.sv */
// ============================================================================
// Crossover signal port checker
// Concurrent checks on the ports of the crossover signal block, attached to
// the top level by a bind statement.
// ============================================================================
module macs_port_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [macs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [macs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [macs_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   input logic                              csr_valid,
   input logic                              csr_ready,
   input logic [macs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [macs_pkg::CSR_DATA_W-1:0]   csr_data
);
   import macs_pkg::*;

   // A stalled result beat holds its payload.
   rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Reset empties the response queue.
   rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending right after reset");

   // Every order carries at least one lot.
   qty_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[SYM_W+QTY_W-1:SYM_W] != '0))
      else $error("order with zero quantity");

   // A result into an empty queue comes from a beat taken through the stage 1 to 4 registers.
   rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 5))
      else $error("result without a matching request beat");

endmodule

bind moving_average_crossover_signal macs_port_checker u_port_checker (.*);
